>>> rtl/core/skf_pkg.sv
// Shared constants, register codes and controller/datapath types for the scalar Kalman filter.
`timescale 1ns / 1ps
package skf_pkg;

	localparam int DATA_W        = 32;
	localparam int GAIN_W        = 17;
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd655;
	localparam logic [DATA_W-1:0] MEAS_NOISE_RST    = 32'd6554;
	localparam logic [DATA_W-1:0] INIT_EST_RST      = 32'd65536;
	localparam logic [DATA_W-1:0] INIT_COV_RST      = 32'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE = 2'd0,
		REG_MEAS_NOISE    = 2'd1,
		REG_INIT_EST      = 2'd2,
		REG_INIT_COV      = 2'd3
	} cfg_reg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic predict;
		logic div_first;
		logic div_step;
		logic mul_corr;
		logic mul_cov;
		logic commit;
	} skf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic restart;
	} skf_stat_t;

endpackage

>>> rtl/core/skf_channels.sv
// Valid/ready channel interfaces for filter items and results.
`timescale 1ns / 1ps
interface skf_in_if
	import skf_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [DATA_W-1:0] measurement;

	modport source (output valid, output mode, output measurement, input ready);
	modport sink (input valid, input mode, input measurement, output ready);
endinterface

interface skf_out_if
	import skf_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] estimate;
	logic        [GAIN_W-1:0] gain;
	logic        [DATA_W-1:0] covariance;

	modport source (output valid, output estimate, output gain, output covariance, input ready);
	modport sink (input valid, input estimate, input gain, input covariance, output ready);
endinterface

>>> rtl/core/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter: controller, datapath and channel wiring.
//
//  channel  | dir | payload                         | handshake
//  in_ch    | in  | mode, measurement               | valid/ready
//  out_ch   | out | estimate, gain, covariance      | valid/ready
//  cfg      | in  | cfg_index, cfg_wdata            | cfg_we, no stall
//
// A measurement passes through predict, the FRAC_BITS + 1 steps of the restoring
// divider for the gain, the correction and covariance multiplies and commit;
// a restart goes from predict straight to commit. One item is in flight at a time.
// A finished result waits in the output stage; the next item is accepted and
// computed meanwhile, and its commit holds until the waiting result is taken.
// Reset loads the configuration and filter state with their reset values.
`timescale 1ns / 1ps
module scalar_kalman_filter_unit
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	skf_in_if.sink               in_ch,
	skf_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	skf_cmd_t  cmd;
	skf_stat_t stat;
	logic      in_ready;
	logic      out_valid;

	skf_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	skf_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_mode        (in_ch.mode),
		.in_measurement (in_ch.measurement),
		.cmd            (cmd),
		.stat           (stat),
		.estimate       (out_ch.estimate),
		.gain           (out_ch.gain),
		.covariance     (out_ch.covariance)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

endmodule

>>> rtl/core/skf_ctrl.sv
// Sequencing state machine for the scalar Kalman filter.
`timescale 1ns / 1ps
module skf_ctrl
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  skf_stat_t stat,
	output skf_cmd_t  cmd
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_DIV,
		ST_MUL_CORR,
		ST_MUL_COV,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             commit_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign commit_ok = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Decode datapath commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.predict   = (state_q == ST_PRED);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.mul_corr  = (state_q == ST_MUL_CORR);
		cmd.mul_cov   = (state_q == ST_MUL_COV);
		cmd.commit    = commit_ok;
	end

	// Advance state, divide step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PRED;
					end
				end
				ST_PRED: begin
					cnt_q   <= '0;
					state_q <= stat.restart ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS)) begin
						state_q <= ST_MUL_CORR;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL_CORR: begin
					state_q <= ST_MUL_COV;
				end
				ST_MUL_COV: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/skf_dp.sv
// Datapath: configuration, filter state, restoring divider and shared multiplier.
`timescale 1ns / 1ps
module skf_dp
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_wdata,
	input  logic                     in_mode,
	input  logic signed [DATA_W-1:0] in_measurement,
	input  skf_cmd_t                 cmd,
	output skf_stat_t                stat,
	output logic signed [DATA_W-1:0] estimate,
	output logic [GAIN_W-1:0]        gain,
	output logic [DATA_W-1:0]        covariance
);

	localparam int QW   = FRAC_BITS + 1;
	localparam int MA_W = DATA_W + 2;
	localparam int MB_W = FRAC_BITS + 2;
	localparam int PW   = MA_W + MB_W;
	localparam logic [QW-1:0] ONE_FIX = QW'(1) << FRAC_BITS;

	// Configuration registers
	logic [DATA_W-1:0] q_q, r_q, init_est_q, init_cov_q;
	// Filter state and item capture
	logic [DATA_W-1:0] est_q, cov_q;
	logic              mode_q;
	logic [DATA_W-1:0] meas_q;
	// Working registers
	logic [DATA_W-1:0]       p_q;
	logic [DATA_W:0]         sum_q;
	logic                    sum_zero_q;
	logic signed [DATA_W:0]  diff_q;
	logic [DATA_W+1:0]       rem_q;
	logic [QW-1:0]           quo_q;
	logic signed [PW-1:0]    prod_q;
	logic [DATA_W-1:0]       est_new_q;
	logic [GAIN_W-1:0]       gain_out_q;

	logic [DATA_W:0]         p_sum;
	logic [DATA_W-1:0]       p_sat;
	logic [DATA_W+1:0]       trial;
	logic                    ge;
	logic [QW-1:0]           gain_eff;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic [QW+GAIN_W-1:0]    gain_wide;

	// Predict covariance with saturation
	assign p_sum = {1'b0, cov_q} + {1'b0, q_q};
	assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

	// One restoring divide step; the first step does not shift
	assign trial = cmd.div_first ? rem_q : {rem_q[DATA_W:0], 1'b0};
	assign ge    = (trial >= {1'b0, sum_q});

	assign gain_eff = sum_zero_q ? '0 : quo_q;

	// Share one multiplier between correction and covariance update
	always_comb begin
		if (cmd.mul_cov) begin
			mul_a = {2'b00, p_q};
			mul_b = {1'b0, ONE_FIX - gain_eff};
		end else begin
			mul_a = {diff_q[DATA_W], diff_q};
			mul_b = {1'b0, gain_eff};
		end
	end

	assign gain_wide = {{GAIN_W{1'b0}}, gain_eff};

	// Write configuration and commit filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q        <= PROCESS_NOISE_RST;
			r_q        <= MEAS_NOISE_RST;
			init_est_q <= INIT_EST_RST;
			init_cov_q <= INIT_COV_RST;
			est_q      <= INIT_EST_RST;
			cov_q      <= INIT_COV_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROCESS_NOISE: q_q        <= cfg_wdata;
					REG_MEAS_NOISE:    r_q        <= cfg_wdata;
					REG_INIT_EST:      init_est_q <= cfg_wdata;
					REG_INIT_COV:      init_cov_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				if (mode_q) begin
					est_q <= init_est_q;
					cov_q <= init_cov_q;
				end else begin
					est_q <= est_new_q;
					cov_q <= prod_q[FRAC_BITS +: DATA_W];
				end
			end
		end
	end

	// Capture item, predict, divide, multiply
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			meas_q <= in_measurement;
		end
		if (cmd.predict) begin
			p_q        <= p_sat;
			sum_q      <= {1'b0, p_sat} + {1'b0, r_q};
			sum_zero_q <= (p_sat == '0) && (r_q == '0);
			diff_q     <= $signed({meas_q[DATA_W-1], meas_q}) - $signed({est_q[DATA_W-1], est_q});
			rem_q      <= {2'b00, p_sat};
			quo_q      <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? (trial - {1'b0, sum_q}) : trial;
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (cmd.mul_corr || cmd.mul_cov) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mul_cov) begin
			est_new_q <= est_q + prod_q[FRAC_BITS +: DATA_W];
		end
		if (cmd.commit) begin
			gain_out_q <= mode_q ? '0 : gain_wide[GAIN_W-1:0];
		end
	end

	assign stat.restart = mode_q;
	assign estimate     = est_q;
	assign gain         = gain_out_q;
	assign covariance   = cov_q;

endmodule
